FILE: rtl/cbrf_pkg.sv
// ----------------------------------------------------------------------------
// cbrf_pkg
// shared types, constants and helpers of the cubic bisection root finder
// ----------------------------------------------------------------------------
package cbrf_pkg;

    localparam int DATA_W        = 21;   // signed fixed point operand width
    localparam int TOL_W         = 20;   // unsigned tolerance width
    localparam int CNT_W         = 6;    // pass counter width
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_ITER_DEF  = 32;

    typedef enum logic [1:0] {
        OUT_CONVERGED = 2'd0,
        OUT_NO_CHANGE = 2'd1,
        OUT_LIMIT     = 2'd2
    } outcome_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL_A,
        S_EVAL_B,
        S_EVAL_C,
        S_CHECK,
        S_DONE
    } seq_state_t;

    // evaluator phases
    typedef enum logic [1:0] {
        EP_IDLE,
        EP_SQUARE,
        EP_CUBE,
        EP_SUM
    } eval_phase_t;

    typedef struct packed {
        logic zero;
        logic neg;
    } sign_t;

    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] x;
    } eval_req_t;

    typedef struct packed {
        logic  done;
        sign_t sgn;
    } eval_rsp_t;

    // true when the two signs are strictly opposite (product below zero)
    function automatic logic opposite(sign_t p, sign_t q);
        opposite = !p.zero && !q.zero && (p.neg != q.neg);
    endfunction

endpackage

FILE: rtl/cbrf_in_if.sv
// ----------------------------------------------------------------------------
// cbrf_in_if
// request channel: interval ends and tolerance
// ----------------------------------------------------------------------------
interface cbrf_in_if import cbrf_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] lower_end;
    logic signed [DATA_W-1:0] upper_end;
    logic        [TOL_W-1:0]  tolerance;

    modport source (output valid, lower_end, upper_end, tolerance, input ready);
    modport sink   (input valid, lower_end, upper_end, tolerance, output ready);
endinterface

FILE: rtl/cbrf_out_if.sv
// ----------------------------------------------------------------------------
// cbrf_out_if
// result channel: root estimate, pass count and outcome
// ----------------------------------------------------------------------------
interface cbrf_out_if import cbrf_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] root_estimate;
    logic        [CNT_W-1:0]  pass_count;
    outcome_t                 outcome;

    modport source (output valid, root_estimate, pass_count, outcome, input ready);
    modport sink   (input valid, root_estimate, pass_count, outcome, output ready);
endinterface

FILE: rtl/cbrf_eval.sv
// ----------------------------------------------------------------------------
// cbrf_eval
// sign of x^3 + 12x - 12 on one shared multiplier, in the phases square, cube and sum
// ----------------------------------------------------------------------------
module cbrf_eval import cbrf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  eval_req_t req,
    output eval_rsp_t rsp
);

    localparam int SQ_W   = 2 * DATA_W - FRAC_BITS;  // square after shift, signed
    localparam int PROD_W = SQ_W + DATA_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam logic signed [ACC_W-1:0] OFFSET = ACC_W'(12 * (2 ** FRAC_BITS));

    eval_phase_t phase_reg, phase_next;

    logic signed [DATA_W-1:0] x_reg;
    logic signed [SQ_W-1:0]   sq_reg;
    logic signed [ACC_W-1:0]  cu_reg;

    logic signed [SQ_W-1:0]   op_a;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  x_ext;
    logic signed [ACC_W-1:0]  sum;

    // shared multiplier: x*x first, then square*x
    assign op_a  = (phase_reg == EP_SQUARE) ? SQ_W'(x_reg) : sq_reg;
    assign prod  = PROD_W'(op_a) * PROD_W'(x_reg);

    assign x_ext = ACC_W'(x_reg);
    assign sum   = cu_reg + (x_ext <<< 3) + (x_ext <<< 2) - OFFSET;

    always_comb
    begin
        phase_next    = phase_reg;
        rsp.done      = 1'b0;
        rsp.sgn.zero  = (sum == '0);
        rsp.sgn.neg   = sum[ACC_W-1];
        unique case (phase_reg)
            EP_IDLE:
            begin
                if (req.start)
                    phase_next = EP_SQUARE;
            end
            EP_SQUARE:  phase_next = EP_CUBE;
            EP_CUBE:    phase_next = EP_SUM;
            EP_SUM:
            begin
                rsp.done   = 1'b1;
                phase_next = req.start ? EP_SQUARE : EP_IDLE;
            end
            default:    phase_next = EP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= EP_IDLE;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
            x_reg <= req.x;
        if (phase_reg == EP_SQUARE)
            sq_reg <= SQ_W'(prod >>> FRAC_BITS);
        if (phase_reg == EP_CUBE)
            cu_reg <= ACC_W'(prod >>> FRAC_BITS);
    end

endmodule

FILE: rtl/cubic_bisection_root_finder_top.sv
// ----------------------------------------------------------------------------
// cubic_bisection_root_finder_top
// bisection search for a root of x^3 + 12x - 12 on a fixed point interval
// ----------------------------------------------------------------------------
// One request carries an interval [lower_end, upper_end] and a tolerance, all
// fixed point with FRAC_BITS fraction bits. The block returns one result per
// request: the last midpoint, the number of passes and an outcome (converged,
// no sign change, or pass limit reached). The cubic is evaluated on a single
// shared multiplier in the steps square, cube and sum. The signs at both
// ends are evaluated once at the start; then each pass evaluates the
// midpoint, whose last step also picks the half, and then checks the width.
// A pass that stops on an exact zero or on no sign change skips the width
// check. The done state loads the result register, and the request side
// opens again in the same cycle as the result shows. A stalled result
// register holds the done state until it is free. The request side is
// ready only while the sequencer is idle; a finished result sits in an
// output register, so a new request may be taken while the previous result
// still waits to be taken.
// ----------------------------------------------------------------------------
module cubic_bisection_root_finder_top import cbrf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int MAX_ITER  = MAX_ITER_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    cbrf_in_if.sink     req_ch,
    cbrf_out_if.source  rsp_ch
);

    localparam logic [CNT_W-1:0] PASS_LIMIT = CNT_W'(MAX_ITER);

    seq_state_t state_reg, state_next;

    // search interval and cached end signs
    logic signed [DATA_W-1:0] a_reg, a_next;
    logic signed [DATA_W-1:0] b_reg, b_next;
    logic signed [DATA_W-1:0] c_reg, c_next;
    logic        [TOL_W-1:0]  tol_reg, tol_next;
    sign_t                    sa_reg, sa_next;
    sign_t                    sb_reg, sb_next;
    logic        [CNT_W-1:0]  pass_reg, pass_next;
    outcome_t                 status_reg, status_next;

    // result register
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_root_reg, out_root_next;
    logic        [CNT_W-1:0]  out_pass_reg, out_pass_next;
    outcome_t                 out_status_reg, out_status_next;

    eval_req_t eval_req;
    eval_rsp_t eval_rsp;

    // midpoint: floor((a + b) / 2) from the exact sum
    logic signed [DATA_W:0]   mid_sum;
    logic signed [DATA_W-1:0] mid;
    // interval width for the stop test
    logic signed [DATA_W:0]   width;
    logic        [DATA_W:0]   width_abs;
    logic                     in_tol;

    assign mid_sum   = (DATA_W+1)'(a_reg) + (DATA_W+1)'(b_reg);
    assign mid       = mid_sum[DATA_W:1];
    assign width     = (DATA_W+1)'(b_reg) - (DATA_W+1)'(a_reg);
    assign width_abs = width[DATA_W] ? (DATA_W+1)'(-width) : (DATA_W+1)'(width);
    assign in_tol    = width_abs <= (DATA_W+1)'(tol_reg);

    cbrf_eval #(
        .FRAC_BITS (FRAC_BITS)
    ) u_eval (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (eval_req),
        .rsp   (eval_rsp)
    );

    assign req_ch.ready         = (state_reg == S_IDLE);
    assign rsp_ch.valid         = out_valid_reg;
    assign rsp_ch.root_estimate = out_root_reg;
    assign rsp_ch.pass_count    = out_pass_reg;
    assign rsp_ch.outcome       = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        c_next          = c_reg;
        tol_next        = tol_reg;
        sa_next         = sa_reg;
        sb_next         = sb_reg;
        pass_next       = pass_reg;
        status_next     = status_reg;
        out_root_next   = out_root_reg;
        out_pass_next   = out_pass_reg;
        out_status_next = out_status_reg;
        eval_req.start  = 1'b0;
        eval_req.x      = mid;

        // result taken downstream
        out_valid_next  = out_valid_reg && !rsp_ch.ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_ch.valid)
                begin
                    a_next         = req_ch.lower_end;
                    b_next         = req_ch.upper_end;
                    tol_next       = req_ch.tolerance;
                    pass_next      = '0;
                    eval_req.start = 1'b1;
                    eval_req.x     = req_ch.lower_end;
                    state_next     = S_EVAL_A;
                end
            end
            S_EVAL_A:
            begin
                eval_req.x = b_reg;
                if (eval_rsp.done)
                begin
                    sa_next        = eval_rsp.sgn;
                    eval_req.start = 1'b1;
                    state_next     = S_EVAL_B;
                end
            end
            S_EVAL_B:
            begin
                if (eval_rsp.done)
                begin
                    // first pass starts here
                    sb_next        = eval_rsp.sgn;
                    c_next         = mid;
                    pass_next      = pass_reg + CNT_W'(1);
                    eval_req.start = 1'b1;
                    state_next     = S_EVAL_C;
                end
            end
            S_EVAL_C:
            begin
                if (eval_rsp.done)
                begin
                    if (eval_rsp.sgn.zero)
                    begin
                        // exact zero at the midpoint
                        status_next = OUT_CONVERGED;
                        state_next  = S_DONE;
                    end
                    else if (opposite(sa_reg, eval_rsp.sgn))
                    begin
                        b_next     = c_reg;
                        sb_next    = eval_rsp.sgn;
                        state_next = S_CHECK;
                    end
                    else if (opposite(sb_reg, eval_rsp.sgn))
                    begin
                        a_next     = c_reg;
                        sa_next    = eval_rsp.sgn;
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        status_next = OUT_NO_CHANGE;
                        state_next  = S_DONE;
                    end
                end
            end
            S_CHECK:
            begin
                if (in_tol)
                begin
                    status_next = OUT_CONVERGED;
                    state_next  = S_DONE;
                end
                else if (pass_reg >= PASS_LIMIT)
                begin
                    status_next = OUT_LIMIT;
                    state_next  = S_DONE;
                end
                else
                begin
                    c_next         = mid;
                    pass_next      = pass_reg + CNT_W'(1);
                    eval_req.start = 1'b1;
                    state_next     = S_EVAL_C;
                end
            end
            S_DONE:
            begin
                // hand over once the result register is free
                if (!out_valid_reg || rsp_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_root_next   = c_reg;
                    out_pass_next   = pass_reg;
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        c_reg          <= c_next;
        tol_reg        <= tol_next;
        sa_reg         <= sa_next;
        sb_reg         <= sb_next;
        pass_reg       <= pass_next;
        status_reg     <= status_next;
        out_root_reg   <= out_root_next;
        out_pass_reg   <= out_pass_next;
        out_status_reg <= out_status_next;
    end

    // a taken request keeps the request side closed while the search runs
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
        else $error("request side open right after a request was taken");

    // every result ran at least one pass and never more than the limit
    a_pass_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_ch.valid |-> (rsp_ch.pass_count != '0) && (rsp_ch.pass_count <= PASS_LIMIT))
        else $error("pass count out of range");

    // the limit outcome only comes with a full pass count
    a_limit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_ch.valid && (rsp_ch.outcome == OUT_LIMIT)) |-> (rsp_ch.pass_count == PASS_LIMIT))
        else $error("limit outcome without full pass count");

    // evaluator finishes only while the sequencer waits on it
    a_eval_owner: assert property (@(posedge clk) disable iff (!rst_n)
        eval_rsp.done |->
            (state_reg == S_EVAL_A) || (state_reg == S_EVAL_B) || (state_reg == S_EVAL_C))
        else $error("evaluator result with no one waiting");

endmodule
